FILE: sv/assert_macros.svh
// Assertion macros shared by the box filter RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define BOXF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("%m: assertion failed");

// Condition must never be true outside reset.
`define BOXF_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("%m: forbidden condition seen");

`endif

FILE: sv/boxf_pkg.sv
// Shared constants, codes and beat types of the 3x3 box filter.
package boxf_pkg;

    localparam int MAX_SIZE    = 1024;
    localparam int PIX_BITS    = 8;
    localparam int COORD_W     = $clog2(MAX_SIZE);
    localparam int SIZE_W      = $clog2(MAX_SIZE + 1);
    localparam int PIX_MAX     = (1 << PIX_BITS) - 1;
    localparam int CS_W        = $clog2(3 * PIX_MAX + 1);
    localparam int SUM_W       = $clog2(9 * PIX_MAX + 5);
    localparam int ROUND_BIAS  = 4;
    // x / 9 as (x * ceil(2^k / 9)) >> k, exact for x below 2^SUM_W
    localparam int RECIP_SHIFT = SUM_W + 4;
    localparam int RECIP_9     = (1 << RECIP_SHIFT) / 9 + 1;
    localparam int RECIP_W     = RECIP_SHIFT - 3;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);
    // up to two results in each of two stages ahead of the output queue
    localparam int PEND_W      = 3;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_DRAIN = 1'b1
    } t_req;

    // command from the control stage to the datapath
    typedef struct packed {
        logic                valid;
        logic                is_pix;
        logic [COORD_W-1:0]  addr;
        logic [PIX_BITS-1:0] pix;
        logic                top;
        logic                has_a;
        logic                emit1;
        logic                emit2;
        logic                cap0;
        logic                use_mid;
        logic                new_ok;
        logic                first;
        logic                frame_end;
        logic [COORD_W-1:0]  row;
        logic [COORD_W-1:0]  col1;
        logic [COORD_W-1:0]  col2;
    } t_cmd;

    // line store write port
    typedef struct packed {
        logic                en;
        logic [COORD_W-1:0]  addr;
        logic [PIX_BITS-1:0] upper;
        logic [PIX_BITS-1:0] middle;
    } t_wr;

    // one result beat
    typedef struct packed {
        logic [PIX_BITS-1:0] mean;
        logic [COORD_W-1:0]  out_row;
        logic [COORD_W-1:0]  out_col;
        logic                run_last;
        logic                frame_end;
    } t_res;

    // up to two results pushed into the output queue in one cycle
    typedef struct packed {
        logic en1;
        logic en2;
        t_res res1;
        t_res res2;
    } t_push;

endpackage

FILE: sv/boxf_in_if.sv
// Input pixel/drain channel of the box filter.
interface boxf_in_if;
    import boxf_pkg::*;

    logic                valid;
    logic                ready;
    logic                req_type;
    logic [PIX_BITS-1:0] pixel;

    modport source (output valid, output req_type, output pixel, input ready);
    modport sink   (input valid, input req_type, input pixel, output ready);
endinterface

FILE: sv/boxf_out_if.sv
// Result channel of the box filter.
interface boxf_out_if;
    import boxf_pkg::*;

    logic                valid;
    logic                ready;
    logic [PIX_BITS-1:0] mean;
    logic [COORD_W-1:0]  out_row;
    logic [COORD_W-1:0]  out_col;
    logic                run_last;
    logic                frame_end;

    modport source (output valid, output mean, output out_row, output out_col,
                    output run_last, output frame_end, input ready);
    modport sink   (input valid, input mean, input out_row, input out_col,
                    input run_last, input frame_end, output ready);
endinterface

FILE: sv/boxf_cfg_if.sv
// Image size write channel of the box filter.
interface boxf_cfg_if;
    import boxf_pkg::*;

    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/boxf_line_buf.sv
// Two line stores (rows r-2 and r-1) with registered read and write forwarding.
`include "assert_macros.svh"

module boxf_line_buf (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [boxf_pkg::COORD_W-1:0]  i_rd_addr,
    input  boxf_pkg::t_wr                 i_wr,
    output logic [boxf_pkg::PIX_BITS-1:0] o_rd_upper,
    output logic [boxf_pkg::PIX_BITS-1:0] o_rd_middle
);
    import boxf_pkg::*;

    logic [PIX_BITS-1:0] r_upper_mem  [MAX_SIZE];
    logic [PIX_BITS-1:0] r_middle_mem [MAX_SIZE];
    logic [PIX_BITS-1:0] r_rd_upper;
    logic [PIX_BITS-1:0] r_rd_middle;
    logic [COORD_W-1:0]  r_rd_addr;
    logic                r_fw_valid;
    logic [COORD_W-1:0]  r_fw_addr;
    logic [PIX_BITS-1:0] r_fw_upper;
    logic [PIX_BITS-1:0] r_fw_middle;
    logic                fw_hit;

    // memories: read-before-write, registered read data
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_upper_mem[i_wr.addr]  <= i_wr.upper;
            r_middle_mem[i_wr.addr] <= i_wr.middle;
        end
        if (i_rd_en) begin
            r_rd_upper  <= r_upper_mem[i_rd_addr];
            r_rd_middle <= r_middle_mem[i_rd_addr];
            r_rd_addr   <= i_rd_addr;
        end
    end

    // remember the write of the read cycle for forwarding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_valid <= 1'b0;
        end else begin
            r_fw_valid <= i_wr.en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fw_addr   <= i_wr.addr;
        r_fw_upper  <= i_wr.upper;
        r_fw_middle <= i_wr.middle;
    end

    // same-entry write in the read cycle wins over the stale memory word
    always_comb begin
        fw_hit      = r_fw_valid && (r_fw_addr == r_rd_addr);
        o_rd_upper  = fw_hit ? r_fw_upper  : r_rd_upper;
        o_rd_middle = fw_hit ? r_fw_middle : r_rd_middle;
    end

    `BOXF_ASSERT(a_fwd_same_entry, i_clk, i_rst_n, (i_wr.en && i_rd_en && (i_wr.addr == i_rd_addr)) |=> ((o_rd_middle == $past(i_wr.middle)) && (o_rd_upper == $past(i_wr.upper))))

endmodule

FILE: sv/boxf_ctrl.sv
// Frame position counters, size register and per-beat command decode.
`include "assert_macros.svh"

module boxf_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_acc,
    input  logic                          i_req_type,
    input  logic [boxf_pkg::PIX_BITS-1:0] i_pixel,
    input  logic                          i_cfg_wr,
    input  logic [boxf_pkg::SIZE_W-1:0]   i_cfg_data,
    output logic                          o_rd_en,
    output logic [boxf_pkg::COORD_W-1:0]  o_rd_addr,
    output boxf_pkg::t_cmd                o_cmd
);
    import boxf_pkg::*;

    logic [SIZE_W-1:0]  r_size, n_size;
    logic [SIZE_W-1:0]  r_in_row, n_in_row;
    logic [COORD_W-1:0] r_in_col, n_in_col;
    logic [COORD_W-1:0] r_dcol, n_dcol;
    t_cmd               r_cmd, n_cmd;

    logic               is_pix;
    logic               frame_in;
    logic               pix_ok;
    logic               drain_ok;
    logic [SIZE_W-1:0]  col_inc;
    logic [SIZE_W-1:0]  dcol_inc;
    logic [SIZE_W-1:0]  row_inc;
    logic [SIZE_W-1:0]  row_m1;
    logic [SIZE_W-1:0]  size_m1;
    logic               col_last;
    logic               drain_last;
    logic [SIZE_W-1:0]  size_clamped;

    // decode of the current beat
    always_comb begin
        is_pix     = (i_req_type == REQ_PIXEL);
        col_inc    = SIZE_W'(r_in_col) + SIZE_W'(1);
        dcol_inc   = SIZE_W'(r_dcol) + SIZE_W'(1);
        row_inc    = r_in_row + SIZE_W'(1);
        row_m1     = r_in_row - SIZE_W'(1);
        size_m1    = r_size - SIZE_W'(1);
        frame_in   = (r_in_row >= r_size);
        pix_ok     = i_in_acc && is_pix && !frame_in;
        drain_ok   = i_in_acc && !is_pix && frame_in;
        col_last   = (col_inc == r_size);
        drain_last = (dcol_inc == r_size);

        if (i_cfg_data == '0) begin
            size_clamped = SIZE_W'(1);
        end else if (i_cfg_data > SIZE_W'(MAX_SIZE)) begin
            size_clamped = SIZE_W'(MAX_SIZE);
        end else begin
            size_clamped = i_cfg_data;
        end
    end

    // counter updates; a size write restarts the frame
    always_comb begin
        n_size   = r_size;
        n_in_row = r_in_row;
        n_in_col = r_in_col;
        n_dcol   = r_dcol;

        if (pix_ok) begin
            if (col_last) begin
                n_in_col = '0;
                n_in_row = row_inc;
            end else begin
                n_in_col = col_inc[COORD_W-1:0];
            end
        end

        if (drain_ok) begin
            if (drain_last) begin
                n_in_row = '0;
                n_in_col = '0;
                n_dcol   = '0;
            end else begin
                n_dcol = dcol_inc[COORD_W-1:0];
            end
        end

        if (i_cfg_wr) begin
            n_size   = size_clamped;
            n_in_row = '0;
            n_in_col = '0;
            n_dcol   = '0;
        end
    end

    // command for the datapath stage
    always_comb begin
        n_cmd.valid     = pix_ok || drain_ok;
        n_cmd.is_pix    = is_pix;
        n_cmd.addr      = is_pix ? r_in_col : dcol_inc[COORD_W-1:0];
        n_cmd.pix       = i_pixel;
        n_cmd.top       = (r_in_row >= SIZE_W'(2));
        n_cmd.has_a     = (r_in_col >= COORD_W'(2));
        n_cmd.emit1     = is_pix ? ((r_in_row != '0) && (r_in_col != '0)) : 1'b1;
        n_cmd.emit2     = is_pix && (r_in_row != '0) && col_last;
        n_cmd.cap0      = is_pix && (row_inc == r_size) && (r_in_col == '0);
        n_cmd.use_mid   = (r_size >= SIZE_W'(2));
        n_cmd.new_ok    = (dcol_inc < r_size);
        n_cmd.first     = (r_dcol == '0);
        n_cmd.frame_end = !is_pix && drain_last;
        n_cmd.row       = is_pix ? row_m1[COORD_W-1:0] : size_m1[COORD_W-1:0];
        n_cmd.col1      = is_pix ? (r_in_col - COORD_W'(1)) : r_dcol;
        n_cmd.col2      = r_in_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size    <= SIZE_W'(MAX_SIZE);
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_dcol    <= '0;
            r_cmd.valid <= 1'b0;
        end else begin
            r_size   <= n_size;
            r_in_row <= n_in_row;
            r_in_col <= n_in_col;
            r_dcol   <= n_dcol;
            r_cmd    <= n_cmd;
        end
    end

    assign o_rd_en   = n_cmd.valid;
    assign o_rd_addr = n_cmd.addr;
    assign o_cmd     = r_cmd;

    `BOXF_ASSERT_NEVER(a_row_in_frame, i_clk, i_rst_n, r_in_row > r_size)
    `BOXF_ASSERT(a_frame_end_restart, i_clk, i_rst_n, (r_cmd.valid && r_cmd.frame_end) |-> ((r_in_row == '0) && (r_in_col == '0) && (r_dcol == '0)))

endmodule

FILE: sv/boxf_datapath.sv
// Column sums, window sums, rounded divide by nine and result assembly.
`include "assert_macros.svh"

module boxf_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  boxf_pkg::t_cmd                i_cmd,
    input  logic [boxf_pkg::PIX_BITS-1:0] i_rd_upper,
    input  logic [boxf_pkg::PIX_BITS-1:0] i_rd_middle,
    output boxf_pkg::t_wr                 o_wr,
    output boxf_pkg::t_push               o_push,
    output logic [boxf_pkg::PEND_W-1:0]   o_pend
);
    import boxf_pkg::*;

    typedef struct packed {
        logic               valid;
        logic               emit2;
        logic               frame_end;
        logic [SUM_W-1:0]   sum1;
        logic [SUM_W-1:0]   sum2;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col1;
        logic [COORD_W-1:0] col2;
    } t_sums;

    // rounded x / 9 through a constant reciprocal
    function automatic logic [PIX_BITS-1:0] div9(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0]         biased;
        logic [SUM_W+RECIP_W-1:0] prod;
        biased = s + SUM_W'(ROUND_BIAS);
        prod   = (SUM_W+RECIP_W)'(biased) * (SUM_W+RECIP_W)'(RECIP_9);
        return prod[RECIP_SHIFT +: PIX_BITS];
    endfunction

    logic [CS_W-1:0]  r_cs_a;
    logic [CS_W-1:0]  r_cs_b;
    logic [CS_W-1:0]  r_dcol0;
    logic [CS_W-1:0]  r_d_prev;
    logic [CS_W-1:0]  r_d_cur;
    t_sums            r_s2, n_s2;

    logic [CS_W-1:0]  cs_new;
    logic [CS_W-1:0]  col0_sum;
    logic [CS_W-1:0]  d_new;
    logic [CS_W-1:0]  d_prev;
    logic [CS_W-1:0]  d_cur;
    logic [SUM_W-1:0] pair_sum;
    logic [SUM_W-1:0] pix_sum;
    logic [SUM_W-1:0] drain_sum;

    // stage 1: column and window sums
    always_comb begin
        cs_new   = CS_W'(i_rd_middle) + CS_W'(i_cmd.pix)
                 + (i_cmd.top ? CS_W'(i_rd_upper) : CS_W'(0));
        col0_sum = CS_W'(i_cmd.pix) + (i_cmd.use_mid ? CS_W'(i_rd_middle) : CS_W'(0));
        pair_sum = SUM_W'(r_cs_b) + SUM_W'(cs_new);
        pix_sum  = pair_sum + (i_cmd.has_a ? SUM_W'(r_cs_a) : SUM_W'(0));

        // last row: two stored rows per column, sliding over columns
        d_new     = i_cmd.new_ok ? (CS_W'(i_rd_upper) + CS_W'(i_rd_middle)) : CS_W'(0);
        d_prev    = i_cmd.first ? CS_W'(0) : r_d_prev;
        d_cur     = i_cmd.first ? r_dcol0 : r_d_cur;
        drain_sum = SUM_W'(d_prev) + SUM_W'(d_cur) + SUM_W'(d_new);

        n_s2.valid     = i_cmd.valid && i_cmd.emit1;
        n_s2.emit2     = i_cmd.emit2;
        n_s2.frame_end = i_cmd.frame_end;
        n_s2.sum1      = i_cmd.is_pix ? pix_sum : drain_sum;
        n_s2.sum2      = pair_sum;
        n_s2.row       = i_cmd.row;
        n_s2.col1      = i_cmd.col1;
        n_s2.col2      = i_cmd.col2;

        // line store shift: middle moves up, new pixel becomes middle
        o_wr.en     = i_cmd.valid && i_cmd.is_pix;
        o_wr.addr   = i_cmd.addr;
        o_wr.upper  = i_rd_middle;
        o_wr.middle = i_cmd.pix;
    end

    // window column registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.is_pix) begin
            r_cs_a <= r_cs_b;
            r_cs_b <= cs_new;
            if (i_cmd.cap0) begin
                r_dcol0 <= col0_sum;
            end
        end
        if (i_cmd.valid && !i_cmd.is_pix) begin
            r_d_prev <= d_cur;
            r_d_cur  <= d_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else begin
            r_s2 <= n_s2;
        end
    end

    // stage 2: divide and build result beats
    always_comb begin
        o_push.en1            = r_s2.valid;
        o_push.en2            = r_s2.valid && r_s2.emit2;
        o_push.res1.mean      = div9(r_s2.sum1);
        o_push.res1.out_row   = r_s2.row;
        o_push.res1.out_col   = r_s2.col1;
        o_push.res1.run_last  = !r_s2.emit2;
        o_push.res1.frame_end = r_s2.frame_end;
        o_push.res2.mean      = div9(r_s2.sum2);
        o_push.res2.out_row   = r_s2.row;
        o_push.res2.out_col   = r_s2.col2;
        o_push.res2.run_last  = 1'b1;
        o_push.res2.frame_end = 1'b0;

        // results still on their way to the output queue
        o_pend = PEND_W'(n_s2.valid) + PEND_W'(n_s2.valid && n_s2.emit2)
               + PEND_W'(r_s2.valid) + PEND_W'(r_s2.valid && r_s2.emit2);
    end

    `BOXF_ASSERT(a_pair_is_pixel, i_clk, i_rst_n, (i_cmd.valid && i_cmd.emit2) |-> (i_cmd.emit1 && i_cmd.is_pix && !i_cmd.frame_end))

endmodule

FILE: sv/boxf_out_fifo.sv
// Output queue taking up to two result beats per cycle, with input credit.
`include "assert_macros.svh"

module boxf_out_fifo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  boxf_pkg::t_push             i_push,
    input  logic [boxf_pkg::PEND_W-1:0] i_pend,
    input  logic                        i_ready,
    output logic                        o_valid,
    output boxf_pkg::t_res              o_res,
    output logic                        o_credit
);
    import boxf_pkg::*;

    t_res               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [FIFO_CW-1:0] r_cnt, n_cnt;
    logic [1:0]         push_cnt;
    logic               pop;
    logic [FIFO_CW:0]   need;

    always_comb begin
        push_cnt = 2'(i_push.en1) + 2'(i_push.en2);
        o_valid  = (r_cnt != '0);
        o_res    = r_mem[r_rd_ptr];
        pop      = o_valid && i_ready;
        n_wr_ptr = r_wr_ptr + FIFO_AW'(push_cnt);
        n_rd_ptr = r_rd_ptr + FIFO_AW'(pop);
        n_cnt    = r_cnt + FIFO_CW'(push_cnt) - FIFO_CW'(pop);
        // room for everything in flight plus two results of a new beat
        need     = (FIFO_CW+1)'(r_cnt) + (FIFO_CW+1)'(i_pend) + (FIFO_CW+1)'(2);
        o_credit = (need <= (FIFO_CW+1)'(FIFO_DEPTH));
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push.en1) begin
            r_mem[r_wr_ptr] <= i_push.res1;
        end
        if (i_push.en2) begin
            r_mem[r_wr_ptr + FIFO_AW'(1)] <= i_push.res2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    `BOXF_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, ((FIFO_CW+1)'(r_cnt) + (FIFO_CW+1)'(push_cnt)) > (FIFO_CW+1)'(FIFO_DEPTH))
    `BOXF_ASSERT_NEVER(a_second_alone, i_clk, i_rst_n, i_push.en2 && !i_push.en1)

endmodule

FILE: sv/box_filter_3x3_zero_pad_core.sv
// Top level of the streaming 3x3 zero-padded box filter.
//
//   channel   dir   beat contents                              accepted when
//   i_in      in    req_type (pixel/drain), pixel              valid && ready
//   o_out     out   mean, out_row, out_col, run_last, frame_end valid && ready
//   i_cfg     in    data = image side length N                 valid && ready
//
// One input beat per cycle while i_in.ready is high; a pixel result passes the
// command register (beside the registered line store read), the sum register
// and the divide logic into the output queue. Row-end pixels give two results,
// the 8-entry queue absorbs them. i_in.ready drops only when the queue plus
// results in flight leave no room for two more. i_cfg is always ready. Reset
// sets N = 1024 and clears the counters; the line stores need no clearing.

module box_filter_3x3_zero_pad_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    boxf_in_if.sink           i_in,
    boxf_out_if.source        o_out,
    boxf_cfg_if.sink          i_cfg
);
    import boxf_pkg::*;

    t_cmd                cmd;
    t_wr                 wr;
    t_push               push;
    t_res                res;
    logic                rd_en;
    logic [COORD_W-1:0]  rd_addr;
    logic [PIX_BITS-1:0] rd_upper;
    logic [PIX_BITS-1:0] rd_middle;
    logic [PEND_W-1:0]   pend;
    logic                credit;
    logic                res_valid;

    assign i_in.ready  = credit;
    assign i_cfg.ready = 1'b1;

    boxf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_acc   (i_in.valid && credit),
        .i_req_type (i_in.req_type),
        .i_pixel    (i_in.pixel),
        .i_cfg_wr   (i_cfg.valid),
        .i_cfg_data (i_cfg.data),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .o_cmd      (cmd)
    );

    boxf_line_buf u_line_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (rd_en),
        .i_rd_addr   (rd_addr),
        .i_wr        (wr),
        .o_rd_upper  (rd_upper),
        .o_rd_middle (rd_middle)
    );

    boxf_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_rd_upper  (rd_upper),
        .i_rd_middle (rd_middle),
        .o_wr        (wr),
        .o_push      (push),
        .o_pend      (pend)
    );

    boxf_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pend   (pend),
        .i_ready  (o_out.ready),
        .o_valid  (res_valid),
        .o_res    (res),
        .o_credit (credit)
    );

    // result channel
    assign o_out.valid     = res_valid;
    assign o_out.mean      = res.mean;
    assign o_out.out_row   = res.out_row;
    assign o_out.out_col   = res.out_col;
    assign o_out.run_last  = res.run_last;
    assign o_out.frame_end = res.frame_end;

endmodule

FILE: test/box_filter_3x3_zero_pad_core_test.sv
// Self-checking testbench for the streaming 3x3 zero-padded box filter core.
`timescale 1ns / 1ps

module box_filter_3x3_zero_pad_core_test;
    import boxf_pkg::*;

    localparam int WINDOW_AREA   = 9;
    localparam int SETTLE_CYCLES = 12;
    localparam int LIMIT_CYCLES  = 2_000_000;
    localparam int RANDOM_ITEMS  = 780;
    localparam int PARTIAL_ROW   = 24;
    localparam int MAX_PRINTED   = 40;

    // Tracks the filter state and the queue of means still to come out.
    class mean_scoreboard;
        int unsigned         size_n;
        logic [PIX_BITS-1:0] upper_line [MAX_SIZE];
        logic [PIX_BITS-1:0] middle_line [MAX_SIZE];
        int unsigned         win [WINDOW_AREA];
        int unsigned         next_in_row, next_in_col;
        int unsigned         next_out_row, next_out_col;
        t_res                expected_means [$];
        int                  errors;

        function new();
            foreach (upper_line[i]) begin
                upper_line[i]  = '0;
                middle_line[i] = '0;
            end
            size_n = MAX_SIZE;
            errors = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            foreach (win[i]) win[i] = 0;
            next_in_row  = 0;
            next_in_col  = 0;
            next_out_row = 0;
            next_out_col = 0;
        endfunction

        // size write: clamp to 1..MAX_SIZE, drop the frame in progress
        function void set_size(logic [SIZE_W-1:0] value);
            size_n = 32'(value);
            if (size_n < 1) size_n = 1;
            if (size_n > MAX_SIZE) size_n = MAX_SIZE;
            restart_frame();
        endfunction

        // one window column; the top pixel counts only inside the image
        function int unsigned column_sum(int k, bit top);
            return win[3*k+1] + win[3*k+2] + (top ? win[3*k] : 0);
        endfunction

        // rounded mean at the next output position, then advance it
        function t_res next_mean(int unsigned sum);
            t_res r;
            bit   last;
            last        = (next_out_row + 1 == size_n) && (next_out_col + 1 == size_n);
            r.mean      = PIX_BITS'((sum + ROUND_BIAS) / WINDOW_AREA);
            r.out_row   = COORD_W'(next_out_row);
            r.out_col   = COORD_W'(next_out_col);
            r.run_last  = 1'b0;
            r.frame_end = last;
            if (next_out_col + 1 >= size_n) begin
                next_out_col = 0;
                next_out_row++;
            end else begin
                next_out_col++;
            end
            if (last) restart_frame();
            return r;
        endfunction

        // accepted input beat: update state and queue the means it yields
        function void note_beat(t_req kind, logic [PIX_BITS-1:0] pix);
            t_res        outs [2];
            int          cnt;
            int unsigned r, c, s, col;
            bit          top;
            cnt = 0;
            if (kind == REQ_PIXEL) begin
                // pixels past the end of the frame are dropped
                if (next_in_row >= size_n || next_in_col >= size_n) return;
                r = next_in_row;
                c = next_in_col;
                for (int k = 0; k < 6; k++) win[k] = win[k+3];
                win[6] = 32'(upper_line[c]);
                win[7] = 32'(middle_line[c]);
                win[8] = 32'(pix);
                upper_line[c]  = middle_line[c];
                middle_line[c] = pix;
                if (c + 1 >= size_n) begin
                    next_in_col = 0;
                    next_in_row++;
                end else begin
                    next_in_col++;
                end
                if (r >= 1) begin
                    top = (r >= 2);
                    if (c >= 1) begin
                        s = column_sum(1, top) + column_sum(2, top);
                        if (c >= 2) s += column_sum(0, top);
                        outs[cnt] = next_mean(s);
                        cnt++;
                    end
                    // row end: right-edge output of the row above
                    if (c + 1 == size_n) begin
                        s = column_sum(2, top);
                        if (c >= 1) s += column_sum(1, top);
                        outs[cnt] = next_mean(s);
                        cnt++;
                    end
                end
            end else begin
                // drain flushes the last row once the frame is in
                if (next_in_row < size_n || next_out_row >= size_n) return;
                s = 0;
                for (int j = 0; j < 3; j++) begin
                    if (next_out_col + j == 0 || next_out_col + j > size_n) continue;
                    col = next_out_col + j - 1;
                    s += 32'(middle_line[col]);
                    if (size_n >= 2) s += 32'(upper_line[col]);
                end
                outs[cnt] = next_mean(s);
                cnt++;
            end
            if (cnt > 0) outs[cnt-1].run_last = 1'b1;
            for (int k = 0; k < cnt; k++) expected_means.push_back(outs[k]);
        endfunction

        function int outstanding();
            return expected_means.size();
        endfunction

        function void report_mismatch(string what);
            errors++;
            if (errors <= MAX_PRINTED) $display("MISMATCH: %s", what);
        endfunction

        // compare one output beat against the oldest expected mean
        function void check_result(t_res got);
            t_res want;
            if (expected_means.size() == 0) begin
                report_mismatch($sformatf("unexpected result at row %0d col %0d",
                                          got.out_row, got.out_col));
                return;
            end
            want = expected_means.pop_front();
            if (got.mean !== want.mean)
                report_mismatch($sformatf("(%0d,%0d) mean %0d, want %0d",
                                          want.out_row, want.out_col, got.mean, want.mean));
            if (got.out_row !== want.out_row)
                report_mismatch($sformatf("out_row %0d, want %0d", got.out_row, want.out_row));
            if (got.out_col !== want.out_col)
                report_mismatch($sformatf("out_col %0d, want %0d", got.out_col, want.out_col));
            if (got.run_last !== want.run_last)
                report_mismatch($sformatf("(%0d,%0d) run_last %0b, want %0b",
                                          want.out_row, want.out_col,
                                          got.run_last, want.run_last));
            if (got.frame_end !== want.frame_end)
                report_mismatch($sformatf("(%0d,%0d) frame_end %0b, want %0b",
                                          want.out_row, want.out_col,
                                          got.frame_end, want.frame_end));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    boxf_in_if  in_ch ();
    boxf_out_if out_ch ();
    boxf_cfg_if cfg_ch ();

    box_filter_3x3_zero_pad_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    mean_scoreboard sb;
    bit             in_calm;
    bit             out_calm;
    int             calm_timer;
    int             stall_left;
    int             cycle_count;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap(bit calm);
        int roll;
        if (calm) return 0;
        roll = $urandom_range(99, 0);
        if (roll < 70) return 0;
        if (roll < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic logic [PIX_BITS-1:0] rand_pixel();
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 10) return '0;
        if (roll < 20) return PIX_BITS'(PIX_MAX);
        return PIX_BITS'($urandom_range(PIX_MAX, 0));
    endfunction

    // one input beat, after a random gap; returns at the accepting edge
    task automatic send_beat(t_req kind, logic [PIX_BITS-1:0] pix);
        int gap;
        gap = pick_gap(in_calm);
        @(negedge clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.req_type <= kind;
        in_ch.pixel    <= pix;
        do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
        sb.note_beat(kind, pix);
    endtask

    // size write, only once the filter has gone quiet
    task automatic write_image_size(logic [SIZE_W-1:0] value);
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
        sb.set_size(value);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // switch between calm stretches and gappy stretches on each side
    always @(posedge clk) begin
        if (calm_timer == 0) begin
            calm_timer = $urandom_range(400, 50);
            in_calm    = ($urandom_range(3, 0) == 0);
            out_calm   = ($urandom_range(3, 0) == 0);
        end else begin
            calm_timer--;
        end
    end

    // result side back-pressure
    always @(negedge clk) begin
        int g;
        if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            g = pick_gap(out_calm);
            out_ch.ready <= (g == 0);
            if (g > 0) stall_left = g - 1;
        end
    end

    // check every result beat as it is taken
    always @(posedge clk) begin
        t_res got;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got.mean      = out_ch.mean;
            got.out_row   = out_ch.out_row;
            got.out_col   = out_ch.out_col;
            got.run_last  = out_ch.run_last;
            got.frame_end = out_ch.frame_end;
            sb.check_result(got);
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("box_filter_3x3_zero_pad_core_test NOT OK");
            $finish;
        end
    end

    initial begin
        int n;
        int frames;
        int cut;
        int roll;
        int stim_count;

        sb             = new();
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.req_type = 1'b0;
        in_ch.pixel    = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.data    = '0;
        out_ch.ready   = 1'b0;
        in_calm        = 1'b0;
        out_calm       = 1'b0;
        calm_timer     = 0;
        stall_left     = 0;
        cycle_count    = 0;
        stim_count     = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset size: drain before any frame, then part of row 0
        send_beat(REQ_DRAIN, rand_pixel());
        send_beat(REQ_PIXEL, '0);
        send_beat(REQ_PIXEL, PIX_BITS'(PIX_MAX));
        send_beat(REQ_PIXEL, 8'hAA);
        send_beat(REQ_PIXEL, 8'h55);

        // size 0 clamps to 1 and drops the partial frame
        write_image_size('0);
        send_beat(REQ_PIXEL, PIX_BITS'(PIX_MAX));
        send_beat(REQ_PIXEL, 8'h07);          // arrives while flushing: ignored
        send_beat(REQ_DRAIN, rand_pixel());
        send_beat(REQ_DRAIN, rand_pixel());   // new frame not in yet
        send_beat(REQ_PIXEL, '0);
        send_beat(REQ_DRAIN, rand_pixel());

        // 2x2, all corners
        write_image_size(SIZE_W'(2));
        repeat (4) send_beat(REQ_PIXEL, PIX_BITS'(PIX_MAX));
        repeat (2) send_beat(REQ_DRAIN, rand_pixel());

        // 3x3 all white: full window in the center
        write_image_size(SIZE_W'(3));
        repeat (9) send_beat(REQ_PIXEL, PIX_BITS'(PIX_MAX));
        repeat (3) send_beat(REQ_DRAIN, rand_pixel());

        // oversize clamps to the largest image; a partial first row gives nothing yet
        write_image_size({SIZE_W{1'b1}});
        repeat (PARTIAL_ROW) send_beat(REQ_PIXEL, rand_pixel());
        send_beat(REQ_DRAIN, rand_pixel());

        // random sizes and frames, mostly well formed with some noise
        while (stim_count < RANDOM_ITEMS) begin
            roll = $urandom_range(99, 0);
            if (roll < 70) n = $urandom_range(6, 1);
            else if (roll < 95) n = $urandom_range(16, 7);
            else n = $urandom_range(24, 17);
            if (n == 1 && $urandom_range(1, 0) == 1) write_image_size('0);
            else write_image_size(SIZE_W'(n));
            frames = $urandom_range(3, 1);
            for (int f = 0; f < frames && stim_count < RANDOM_ITEMS; f++) begin
                // frame cut short; the next size write drops it
                if ($urandom_range(99, 0) < 12) begin
                    cut = $urandom_range(n * n - 1, 0);
                    for (int i = 0; i < cut; i++) begin
                        if ($urandom_range(99, 0) < 5) send_beat(REQ_DRAIN, rand_pixel());
                        send_beat(REQ_PIXEL, rand_pixel());
                    end
                    stim_count += cut;
                    break;
                end
                for (int i = 0; i < n * n; i++) begin
                    if ($urandom_range(99, 0) < 3) send_beat(REQ_DRAIN, rand_pixel());
                    send_beat(REQ_PIXEL, rand_pixel());
                end
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(99, 0) < 5) send_beat(REQ_PIXEL, rand_pixel());
                    send_beat(REQ_DRAIN, rand_pixel());
                end
                if ($urandom_range(99, 0) < 10) send_beat(REQ_DRAIN, rand_pixel());
                stim_count += n * n + n;
            end
        end

        // let everything drain out
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.errors == 0) begin
            $display("box_filter_3x3_zero_pad_core_test OK");
        end else begin
            $display("box_filter_3x3_zero_pad_core_test NOT OK");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/boxf_pkg.sv
sv/boxf_in_if.sv
sv/boxf_out_if.sv
sv/boxf_cfg_if.sv
sv/boxf_line_buf.sv
sv/boxf_ctrl.sv
sv/boxf_datapath.sv
sv/boxf_out_fifo.sv
sv/box_filter_3x3_zero_pad_core.sv
test/box_filter_3x3_zero_pad_core_test.sv
